[rtl/core/sihr_pkg.sv]
// ----------------------------------------------------------------------------
// sihr_pkg
// Shared constants, codes and types of the shared irq handler registry.
// ----------------------------------------------------------------------------
`default_nettype none

package sihr_pkg;

    // Table geometry
    localparam int SLOTS        = 6;
    localparam int HANDLER_BITS = 32;

    // Stored handler width: the address field is 32 bits wide
    localparam int HW = (HANDLER_BITS < 32) ? HANDLER_BITS : 32;
    // Slot index width and used-count width (count reaches SLOTS)
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // Field widths
    localparam int IRQ_W    = 8;
    localparam int ADDR_W   = 32;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 3;
    localparam int SLOTS_W  = 3;
    localparam int CNT_W    = 16;

    // Operation codes
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DECLINED  = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // Counter select
    typedef enum logic [1:0] {
        CNT_DECLINE = 2'd0,
        CNT_DUP     = 2'd1,
        CNT_REMOVE  = 2'd2
    } t_cnt_sel;

    // Counter bump command
    typedef struct packed {
        logic     inc;
        t_cnt_sel sel;
    } t_cnt_cmd;

    // Table write port
    typedef struct packed {
        logic             en;
        logic [IW-1:0]    idx;
        logic [IRQ_W-1:0] irq;
        logic [HW-1:0]    handler;
    } t_tbl_wr;

endpackage

`default_nettype wire

[rtl/core/sihr_req_if.sv]
// ----------------------------------------------------------------------------
// sihr_req_if
// Request channel: valid/ready handshake with the add/remove request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sihr_req_if;
    import sihr_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [IRQ_W-1:0]  irq_number;
    logic [ADDR_W-1:0] handler_address;
    logic [PRIO_W-1:0] chain_priority;

    modport source (
        output valid, func, irq_number, handler_address, chain_priority,
        input  ready
    );

    modport sink (
        input  valid, func, irq_number, handler_address, chain_priority,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/sihr_rsp_if.sv]
// ----------------------------------------------------------------------------
// sihr_rsp_if
// Result channel: valid/ready handshake with status, slot count and counters.
// ----------------------------------------------------------------------------
`default_nettype none

interface sihr_rsp_if;
    import sihr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                forward;
    logic [PRIO_W-1:0]   forward_priority;
    logic [SLOTS_W-1:0]  slots_used;
    logic [CNT_W-1:0]    declined_count;
    logic [CNT_W-1:0]    deduped_count;
    logic [CNT_W-1:0]    removed_count;

    modport source (
        output valid, status, forward, forward_priority, slots_used,
               declined_count, deduped_count, removed_count,
        input  ready
    );

    modport sink (
        input  valid, status, forward, forward_priority, slots_used,
               declined_count, deduped_count, removed_count,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/sihr_table.sv]
// ----------------------------------------------------------------------------
// sihr_table
// Entry store of (irq, handler) pairs: one write port, one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sihr_table (
    input  wire logic                      i_clk,
    input  wire sihr_pkg::t_tbl_wr         i_wr,
    input  wire logic [sihr_pkg::IW-1:0]   i_rd_idx,
    output logic [sihr_pkg::IRQ_W-1:0]     o_rd_irq,
    output logic [sihr_pkg::HW-1:0]        o_rd_handler
);
    import sihr_pkg::*;

    logic [IRQ_W-1:0] r_irq     [SLOTS];
    logic [HW-1:0]    r_handler [SLOTS];

    // Write port; entries hold no reset value
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_irq[i_wr.idx]     <= i_wr.irq;
            r_handler[i_wr.idx] <= i_wr.handler;
        end
    end

    // Read port
    assign o_rd_irq     = r_irq[i_rd_idx];
    assign o_rd_handler = r_handler[i_rd_idx];

endmodule

`default_nettype wire

[rtl/core/sihr_counters.sv]
// ----------------------------------------------------------------------------
// sihr_counters
// Decline, duplicate and removal counters sharing one saturating incrementer.
// ----------------------------------------------------------------------------
`default_nettype none

module sihr_counters (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sihr_pkg::t_cnt_cmd         i_cmd,
    output logic [sihr_pkg::CNT_W-1:0]      o_declines,
    output logic [sihr_pkg::CNT_W-1:0]      o_duplicates,
    output logic [sihr_pkg::CNT_W-1:0]      o_removals
);
    import sihr_pkg::*;

    logic [CNT_W-1:0] r_declines;
    logic [CNT_W-1:0] r_duplicates;
    logic [CNT_W-1:0] r_removals;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] n_val;

    // Pick the operand for the shared incrementer
    always_comb begin
        case (i_cmd.sel)
            CNT_DECLINE: cur = r_declines;
            CNT_DUP:     cur = r_duplicates;
            CNT_REMOVE:  cur = r_removals;
            default:     cur = r_declines;
        endcase
    end

    // Saturate at all ones
    assign n_val = (&cur) ? cur : cur + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_declines   <= '0;
            r_duplicates <= '0;
            r_removals   <= '0;
        end else if (i_cmd.inc) begin
            case (i_cmd.sel)
                CNT_DECLINE: r_declines   <= n_val;
                CNT_DUP:     r_duplicates <= n_val;
                CNT_REMOVE:  r_removals   <= n_val;
                default:     r_declines   <= r_declines;
            endcase
        end
    end

    assign o_declines   = r_declines;
    assign o_duplicates = r_duplicates;
    assign o_removals   = r_removals;

endmodule

`default_nettype wire

[rtl/core/shared_irq_handler_registry.sv]
// ----------------------------------------------------------------------------
// shared_irq_handler_registry
// Registry of (irq, handler) pairs in front of a handler chain: dedups and
// bounds adds, removes with compaction, and counts declines, dups and removals.
//
//   channel   dir   port     payload
//   request   in    i_req    func, irq_number, handler_address, chain_priority
//   result    out   o_rsp    status, forward, forward_priority, slots_used,
//                            declined_count, deduped_count, removed_count
//
// One request passes an accept step, then the scan and the compaction
// behind a hit, which together visit the table indices from 0 up to at
// most the used count, and then a result step. The single entry comparator
// and the one-port entry store make that walk serial. Reset is synchronous,
// active low, and empties the table and clears the counters. A result
// waiting in the output register does not block the next request; it
// stalls only the result step of the following one.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_irq_handler_registry (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sihr_req_if.sink  i_req,
    sihr_rsp_if.source o_rsp
);
    import sihr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Latched request
    logic              r_func;
    logic [IRQ_W-1:0]  r_irq;
    logic [HW-1:0]     r_handler;
    logic [PRIO_W-1:0] r_prio;

    // Sequencer state
    logic [CW-1:0] r_idx,  n_idx;
    logic [CW-1:0] r_used, n_used;
    t_status       r_status, n_status;
    logic          r_fwd,  n_fwd;
    logic [PRIO_W-1:0] r_fwd_prio, n_fwd_prio;

    // Output register
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic                r_o_fwd;
    logic [PRIO_W-1:0]   r_o_fwd_prio;
    logic [SLOTS_W-1:0]  r_o_slots;
    logic [CNT_W-1:0]    r_o_decl;
    logic [CNT_W-1:0]    r_o_dup;
    logic [CNT_W-1:0]    r_o_rem;

    t_tbl_wr          tbl_wr;
    t_cnt_cmd         cnt_cmd;
    logic [IRQ_W-1:0] rd_irq;
    logic [HW-1:0]    rd_handler;
    logic [CNT_W-1:0] cnt_decl, cnt_dup, cnt_rem;
    logic             match;
    logic             accept;
    logic             load_out;

    sihr_table u_table (
        .i_clk        (i_clk),
        .i_wr         (tbl_wr),
        .i_rd_idx     (r_idx[IW-1:0]),
        .o_rd_irq     (rd_irq),
        .o_rd_handler (rd_handler)
    );

    sihr_counters u_counters (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cnt_cmd),
        .o_declines   (cnt_decl),
        .o_duplicates (cnt_dup),
        .o_removals   (cnt_rem)
    );

    assign i_req.ready = r_state[0];
    assign accept      = i_req.valid & i_req.ready;
    assign load_out    = (r_state == S_DONE) & (~r_o_valid | o_rsp.ready);

    // Shared comparator
    assign match = (rd_irq == r_irq) && (rd_handler == r_handler);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_used     = r_used;
        n_status   = r_status;
        n_fwd      = r_fwd;
        n_fwd_prio = r_fwd_prio;
        tbl_wr     = '{en: 1'b0, idx: r_idx[IW-1:0], irq: r_irq, handler: r_handler};
        cnt_cmd    = '{inc: 1'b0, sel: CNT_DECLINE};

        case (r_state)
            S_IDLE: begin
                n_idx      = '0;
                n_fwd      = 1'b0;
                n_fwd_prio = '0;
                if (accept) begin
                    n_state = S_SCAN;
                end
            end

            // Walk the used entries, one compare per cycle
            S_SCAN: begin
                if (r_idx == r_used) begin
                    n_state = S_DONE;
                    if (r_func == FUNC_ADD) begin
                        if (r_used == CW'(SLOTS)) begin
                            n_status    = ST_DECLINED;
                            cnt_cmd.inc = 1'b1;
                            cnt_cmd.sel = CNT_DECLINE;
                        end else begin
                            tbl_wr.en  = 1'b1;
                            tbl_wr.idx = r_used[IW-1:0];
                            n_used     = r_used + CW'(1);
                            n_status   = ST_ADDED;
                            n_fwd      = 1'b1;
                            n_fwd_prio = r_prio;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_fwd    = 1'b1;
                    end
                end else if (match) begin
                    if (r_func == FUNC_ADD) begin
                        n_state     = S_DONE;
                        n_status    = ST_DUPLICATE;
                        cnt_cmd.inc = 1'b1;
                        cnt_cmd.sel = CNT_DUP;
                    end else begin
                        n_state = S_SHIFT;
                        n_idx   = r_idx + CW'(1);
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end

            // Move later entries down one slot
            S_SHIFT: begin
                if (r_idx == r_used) begin
                    n_state     = S_DONE;
                    n_used      = r_used - CW'(1);
                    n_status    = ST_REMOVED;
                    n_fwd       = 1'b1;
                    cnt_cmd.inc = 1'b1;
                    cnt_cmd.sel = CNT_REMOVE;
                end else begin
                    tbl_wr.en      = 1'b1;
                    tbl_wr.idx     = IW'(r_idx - CW'(1));
                    tbl_wr.irq     = rd_irq;
                    tbl_wr.handler = rd_handler;
                    n_idx          = r_idx + CW'(1);
                end
            end

            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_fwd      <= n_fwd;
        r_fwd_prio <= n_fwd_prio;
        if (accept) begin
            r_func    <= i_req.func;
            r_irq     <= i_req.irq_number;
            r_handler <= i_req.handler_address[HW-1:0];
            r_prio    <= i_req.chain_priority;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_status   <= r_status;
            r_o_fwd      <= r_fwd;
            r_o_fwd_prio <= r_fwd_prio;
            r_o_slots    <= SLOTS_W'(r_used);
            r_o_decl     <= cnt_decl;
            r_o_dup      <= cnt_dup;
            r_o_rem      <= cnt_rem;
        end
    end

    assign o_rsp.valid            = r_o_valid;
    assign o_rsp.status           = r_o_status;
    assign o_rsp.forward          = r_o_fwd;
    assign o_rsp.forward_priority = r_o_fwd_prio;
    assign o_rsp.slots_used       = r_o_slots;
    assign o_rsp.declined_count   = r_o_decl;
    assign o_rsp.deduped_count    = r_o_dup;
    assign o_rsp.removed_count    = r_o_rem;

endmodule

`default_nettype wire

[verif/shared_irq_handler_registry_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_irq_handler_registry_test
// Self-checking bench for the shared irq handler registry. A short table of
// directed requests covers the field extremes, duplicates, a full table, and
// removes that hit or miss. After that, phases of random requests drawn from
// small pools of (irq, handler) pairs fill and drain the table. Every result
// is checked against typed-in values or an in-bench table and counter model,
// under random idling on both channels and one long result-side hold-off.
// ----------------------------------------------------------------------------

module shared_irq_handler_registry_test;
    import sihr_pkg::*;

    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RAND_PHASES     = 7;
    localparam int PHASE_ITEMS     = 200;
    localparam int POOL_SIZE       = 8;
    localparam int DRAIN_CYCLES    = 4 * SLOTS + 8;

    typedef struct {
        logic              func;
        logic [IRQ_W-1:0]  irq;
        logic [ADDR_W-1:0] addr;
        logic [PRIO_W-1:0] prio;
    } t_request;

    typedef struct {
        t_status            status;
        logic               forward;
        logic [PRIO_W-1:0]  fwd_prio;
        logic [SLOTS_W-1:0] slots;
        logic [CNT_W-1:0]   declined;
        logic [CNT_W-1:0]   deduped;
        logic [CNT_W-1:0]   removed;
    } t_outcome;

    typedef struct {
        t_request req;
        bit       typed;
        t_outcome want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    sihr_req_if req_ch ();
    sihr_rsp_if rsp_ch ();

    shared_irq_handler_registry u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Model of the pair table and the outcome counters
    logic [IRQ_W-1:0] tbl_irq     [SLOTS];
    logic [HW-1:0]    tbl_handler [SLOTS];
    int               tbl_used;
    logic [CNT_W-1:0] n_declined;
    logic [CNT_W-1:0] n_deduped;
    logic [CNT_W-1:0] n_removed;

    // Outcomes of accepted requests, oldest first
    t_outcome pending_results [$];

    // Random pair pool of the current phase
    logic [IRQ_W-1:0]  pool_irq  [POOL_SIZE];
    logic [ADDR_W-1:0] pool_addr [POOL_SIZE];

    int errors;
    int requests_sent;
    int results_seen;
    int status_seen [8];
    bit idle_on;
    bit hold_request;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Apply one request to the table model and return its outcome
    function automatic t_outcome predict_outcome(input t_request r);
        t_outcome      o;
        logic [HW-1:0] h;
        int            hit;
        int            i;
        h   = r.addr[HW-1:0];
        hit = tbl_used;
        for (i = 0; i < tbl_used; i++) begin
            if (tbl_irq[i] == r.irq && tbl_handler[i] == h) begin
                hit = i;
                break;
            end
        end
        o.forward  = 1'b0;
        o.fwd_prio = '0;
        if (r.func == FUNC_ADD) begin
            // duplicate check comes before the capacity check
            if (hit < tbl_used) begin
                n_deduped = bump_sat(n_deduped);
                o.status  = ST_DUPLICATE;
            end else if (tbl_used >= SLOTS) begin
                n_declined = bump_sat(n_declined);
                o.status   = ST_DECLINED;
            end else begin
                tbl_irq[tbl_used]     = r.irq;
                tbl_handler[tbl_used] = h;
                tbl_used++;
                o.status   = ST_ADDED;
                o.forward  = 1'b1;
                o.fwd_prio = r.prio;
            end
        end else begin
            // remove: compact entries above the hit; forwarded either way
            if (hit < tbl_used) begin
                for (i = hit + 1; i < tbl_used; i++) begin
                    tbl_irq[i-1]     = tbl_irq[i];
                    tbl_handler[i-1] = tbl_handler[i];
                end
                tbl_used--;
                n_removed = bump_sat(n_removed);
                o.status  = ST_REMOVED;
            end else begin
                o.status = ST_NOT_FOUND;
            end
            o.forward = 1'b1;
        end
        o.slots    = tbl_used[SLOTS_W-1:0];
        o.declined = n_declined;
        o.deduped  = n_deduped;
        o.removed  = n_removed;
        return o;
    endfunction

    // Directed row with its outcome typed in
    function automatic t_dir_row chk_row(
        input logic f, input logic [IRQ_W-1:0] irq, input logic [ADDR_W-1:0] addr,
        input logic [PRIO_W-1:0] prio, input t_status st, input logic fwd,
        input logic [PRIO_W-1:0] fp, input logic [SLOTS_W-1:0] sl,
        input logic [CNT_W-1:0] dec, input logic [CNT_W-1:0] dup,
        input logic [CNT_W-1:0] rem);
        t_dir_row row;
        row.req.func      = f;
        row.req.irq       = irq;
        row.req.addr      = addr;
        row.req.prio      = prio;
        row.typed         = 1'b1;
        row.want.status   = st;
        row.want.forward  = fwd;
        row.want.fwd_prio = fp;
        row.want.slots    = sl;
        row.want.declined = dec;
        row.want.deduped  = dup;
        row.want.removed  = rem;
        return row;
    endfunction

    // Directed row left to the table model
    function automatic t_dir_row free_row(
        input logic f, input logic [IRQ_W-1:0] irq, input logic [ADDR_W-1:0] addr,
        input logic [PRIO_W-1:0] prio);
        t_dir_row row;
        row.req.func = f;
        row.req.irq  = irq;
        row.req.addr = addr;
        row.req.prio = prio;
        row.typed    = 1'b0;
        return row;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                 $time, results_seen, field, got, want);
    endtask

    // Offer one request; entered and left at a falling edge
    task automatic drive_request(input t_request r, input bit typed, input t_outcome want);
        int       gap;
        t_outcome o;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.func            <= r.func;
        req_ch.irq_number      <= r.irq;
        req_ch.handler_address <= r.addr;
        req_ch.chain_priority  <= r.prio;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        o = predict_outcome(r);
        pending_results.push_back(typed ? want : o);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("[%0t] result with no request waiting: status %0d",
                         $time, rsp_ch.status);
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                if (rsp_ch.forward !== want.forward)
                    report_mismatch("forward", 32'(rsp_ch.forward), 32'(want.forward));
                if (rsp_ch.forward_priority !== want.fwd_prio)
                    report_mismatch("forward_priority", 32'(rsp_ch.forward_priority),
                                    32'(want.fwd_prio));
                if (rsp_ch.slots_used !== want.slots)
                    report_mismatch("slots_used", 32'(rsp_ch.slots_used),
                                    32'(want.slots));
                if (rsp_ch.declined_count !== want.declined)
                    report_mismatch("declined_count", 32'(rsp_ch.declined_count),
                                    32'(want.declined));
                if (rsp_ch.deduped_count !== want.deduped)
                    report_mismatch("deduped_count", 32'(rsp_ch.deduped_count),
                                    32'(want.deduped));
                if (rsp_ch.removed_count !== want.removed)
                    report_mismatch("removed_count", 32'(rsp_ch.removed_count),
                                    32'(want.removed));
                status_seen[want.status]++;
            end
            results_seen++;
        end
    end

    // Result-side ready: random stall bursts, one long hold-off on request
    initial begin : result_ready
        int burst;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 16);
                rsp_ch.ready <= 1'b0;
                repeat (burst) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Watchdog: ends the run when no item moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: %0d cycles with no item moving", $time, QUIET_LIMIT);
        $display("shared_irq_handler_registry_test: FAIL");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        t_dir_row rows [$];
        t_request r;
        t_outcome none;
        int       add_pct;
        int       pick;
        int       k;

        i_rst_n                = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.func            = FUNC_ADD;
        req_ch.irq_number      = '0;
        req_ch.handler_address = '0;
        req_ch.chain_priority  = '0;
        idle_on                = 1'b1;
        hold_request           = 1'b0;
        errors                 = 0;
        requests_sent          = 0;
        results_seen           = 0;
        tbl_used               = 0;
        n_declined             = '0;
        n_deduped              = '0;
        n_removed              = '0;
        foreach (status_seen[n]) status_seen[n] = 0;

        // Fill to full with extreme pairs, then duplicates, declines and removes
        rows.push_back(chk_row(FUNC_ADD, 8'h00, 32'h0000_0000, 8'h00,
                               ST_ADDED, 1, 8'h00, 1, 0, 0, 0));
        rows.push_back(chk_row(FUNC_ADD, 8'hFF, 32'hFFFF_FFFF, 8'hFF,
                               ST_ADDED, 1, 8'hFF, 2, 0, 0, 0));
        rows.push_back(chk_row(FUNC_ADD, 8'hFF, 32'hFFFF_FFFF, 8'h07,
                               ST_DUPLICATE, 0, 8'h00, 2, 0, 1, 0));
        // same handler under another irq, same irq with another handler
        rows.push_back(chk_row(FUNC_ADD, 8'h00, 32'hFFFF_FFFF, 8'h80,
                               ST_ADDED, 1, 8'h80, 3, 0, 1, 0));
        rows.push_back(chk_row(FUNC_ADD, 8'hFF, 32'h0000_0000, 8'h01,
                               ST_ADDED, 1, 8'h01, 4, 0, 1, 0));
        rows.push_back(chk_row(FUNC_ADD, 8'h5A, 32'hA5A5_A5A5, 8'h55,
                               ST_ADDED, 1, 8'h55, 5, 0, 1, 0));
        rows.push_back(chk_row(FUNC_ADD, 8'hA5, 32'h5A5A_5A5A, 8'hAA,
                               ST_ADDED, 1, 8'hAA, 6, 0, 1, 0));
        rows.push_back(chk_row(FUNC_ADD, 8'h01, 32'h0000_0001, 8'h03,
                               ST_DECLINED, 0, 8'h00, 6, 1, 1, 0));
        // duplicate on a full table counts as a duplicate
        rows.push_back(chk_row(FUNC_ADD, 8'h00, 32'h0000_0000, 8'h09,
                               ST_DUPLICATE, 0, 8'h00, 6, 1, 2, 0));
        // misses on irq alone and on handler alone, still forwarded
        rows.push_back(chk_row(FUNC_REMOVE, 8'h01, 32'h0000_0000, 8'h11,
                               ST_NOT_FOUND, 1, 8'h00, 6, 1, 2, 0));
        rows.push_back(chk_row(FUNC_REMOVE, 8'h00, 32'h0000_0001, 8'h22,
                               ST_NOT_FOUND, 1, 8'h00, 6, 1, 2, 0));
        // middle, repeat, first and last entry
        rows.push_back(chk_row(FUNC_REMOVE, 8'hFF, 32'hFFFF_FFFF, 8'hFF,
                               ST_REMOVED, 1, 8'h00, 5, 1, 2, 1));
        rows.push_back(chk_row(FUNC_REMOVE, 8'hFF, 32'hFFFF_FFFF, 8'h00,
                               ST_NOT_FOUND, 1, 8'h00, 5, 1, 2, 1));
        rows.push_back(chk_row(FUNC_REMOVE, 8'h00, 32'h0000_0000, 8'h33,
                               ST_REMOVED, 1, 8'h00, 4, 1, 2, 2));
        rows.push_back(chk_row(FUNC_REMOVE, 8'hA5, 32'h5A5A_5A5A, 8'h44,
                               ST_REMOVED, 1, 8'h00, 3, 1, 2, 3));
        rows.push_back(chk_row(FUNC_ADD, 8'hA5, 32'h5A5A_5A5A, 8'h42,
                               ST_ADDED, 1, 8'h42, 4, 1, 2, 3));
        // drain to empty, then a miss on an empty table
        rows.push_back(free_row(FUNC_REMOVE, 8'h00, 32'hFFFF_FFFF, 8'h66));
        rows.push_back(free_row(FUNC_ADD,    8'h5A, 32'hA5A5_A5A5, 8'h77));
        rows.push_back(free_row(FUNC_REMOVE, 8'hFF, 32'h0000_0000, 8'h88));
        rows.push_back(free_row(FUNC_REMOVE, 8'h5A, 32'hA5A5_A5A5, 8'h99));
        rows.push_back(free_row(FUNC_REMOVE, 8'hA5, 32'h5A5A_5A5A, 8'hCC));
        rows.push_back(free_row(FUNC_REMOVE, 8'h00, 32'h0000_0000, 8'hDD));
        rows.push_back(free_row(FUNC_ADD,    8'h80, 32'h8000_0000, 8'h80));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[n]) drive_request(rows[n].req, rows[n].typed, rows[n].want);

        // Random phases: small pair pools so adds, duplicates and removes meet
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (k = 0; k < POOL_SIZE; k++) begin
                pool_irq[k]  = IRQ_W'($urandom_range(0, 255));
                pool_addr[k] = $urandom();
            end
            pool_irq[1]  = pool_irq[0];
            pool_addr[2] = pool_addr[0];
            add_pct = (ph == 0) ? 75 : $urandom_range(30, 75);
            if (ph == 1) hold_request = 1'b1;
            if (ph == RAND_PHASES - 1) idle_on = 1'b0;
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    // noise: a pair from anywhere
                    r.func = 1'($urandom_range(0, 1));
                    r.irq  = IRQ_W'($urandom_range(0, 255));
                    r.addr = $urandom();
                end else begin
                    k      = $urandom_range(0, POOL_SIZE - 1);
                    r.func = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_REMOVE;
                    r.irq  = pool_irq[k];
                    r.addr = pool_addr[k];
                end
                r.prio = PRIO_W'($urandom_range(0, 255));
                drive_request(r, 1'b0, none);
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d directed, %0d random phases), %0d results checked",
                 requests_sent, rows.size(), RAND_PHASES, results_seen);
        $display("outcomes: %0d added, %0d duplicate, %0d declined, %0d removed, %0d not found",
                 status_seen[ST_ADDED], status_seen[ST_DUPLICATE], status_seen[ST_DECLINED],
                 status_seen[ST_REMOVED], status_seen[ST_NOT_FOUND]);
        if (errors == 0)
            $display("shared_irq_handler_registry_test: PASS");
        else
            $display("shared_irq_handler_registry_test: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/sihr_pkg.sv
rtl/core/sihr_req_if.sv
rtl/core/sihr_rsp_if.sv
rtl/core/sihr_table.sv
rtl/core/sihr_counters.sv
rtl/core/shared_irq_handler_registry.sv
verif/shared_irq_handler_registry_test.sv
